>>> hdl/lav_pkg.sv
package lav_pkg;

    localparam int InBits   = 288;
    localparam int OutBits  = 136;
    localparam int ShSteps  = 6;
    localparam int RtSteps  = 31;
    localparam int DvSteps  = 31;
    localparam int ElemFrac = 14;
    localparam int ProdFrac = 30;

    localparam logic [31:0] Q16One = 32'h0001_0000;

    typedef logic signed [31:0] q_t;

    typedef struct packed {
        q_t [2:0] eye;
        q_t [2:0] up;
        q_t [2:0] f;
        logic     ok;
    } side_t;

    function automatic logic signed [63:0] mul32(input q_t a, input q_t b);
        logic signed [63:0] aw;
        logic signed [63:0] bw;
        aw = a;
        bw = b;
        return aw * bw;
    endfunction

    // Right shift that rounds to nearest, ties away from zero.
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x, input int n);
        logic [63:0] m;
        m = x[63] ? (64'd0 - x) : x;
        m = (m + (64'd1 << (n - 1))) >> n;
        return x[63] ? (64'd0 - m) : m;
    endfunction

    function automatic q_t sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return x[31:0];
        end
    endfunction

endpackage

>>> hdl/lav_nrm.sv
module lav_nrm
    import lav_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_vld,
    input  logic [2:0][63:0] in_vec,
    input  side_t            in_side,
    output logic             out_vld,
    output q_t [2:0]         out_unit,
    output logic             out_ok,
    output side_t            out_side
);

    typedef struct packed {
        logic       vld;
        side_t      side;
        logic [2:0] neg;
        logic       zero;
    } hd_t;

    hd_t              hs_reg [ShSteps+1];
    logic [2:0][63:0] ms_reg [ShSteps+1];
    logic [63:0]      xs_reg [ShSteps+1];
    logic [2:0][63:0] ms_next [ShSteps];
    logic [63:0]      xs_next [ShSteps];

    hd_t              hq_reg;
    logic [2:0][29:0] aq_reg;
    logic [2:0][59:0] sq_reg;

    hd_t              hr_reg [RtSteps+1];
    logic [2:0][29:0] ar_reg [RtSteps+1];
    logic [61:0]      rm_reg [RtSteps+1];
    logic [30:0]      ro_reg [RtSteps+1];
    logic [61:0]      rm_next [RtSteps];
    logic [30:0]      ro_next [RtSteps];

    hd_t              hd_reg [DvSteps+1];
    logic [30:0]      ln_reg [DvSteps+1];
    logic [2:0][61:0] dr_reg [DvSteps+1];
    logic [2:0][30:0] qq_reg [DvSteps+1];
    logic [2:0][61:0] dr_next [DvSteps];
    logic [2:0][30:0] qq_next [DvSteps];

    hd_t              ho_reg;
    q_t [2:0]         uo_reg;

    logic [2:0][63:0] abs_next;
    logic [63:0]      max_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_next[i] = in_vec[i][63] ? (64'd0 - in_vec[i]) : in_vec[i];
        end
        max_next = abs_next[0];
        if (abs_next[1] > max_next) begin
            max_next = abs_next[1];
        end
        if (abs_next[2] > max_next) begin
            max_next = abs_next[2];
        end
    end

    // Leading-zero normalization: the largest magnitude ends up with its top bit at bit 63.
    always_comb begin
        for (int k = 0; k < ShSteps; k++) begin
            if ((xs_reg[k] >> (64 - (32 >> k))) == 64'd0) begin
                xs_next[k] = xs_reg[k] << (32 >> k);
                for (int i = 0; i < 3; i++) begin
                    ms_next[k][i] = ms_reg[k][i] << (32 >> k);
                end
            end else begin
                xs_next[k] = xs_reg[k];
                ms_next[k] = ms_reg[k];
            end
        end
    end

    // Restoring square root, one result bit per stage.
    always_comb begin
        logic [63:0] trial;
        for (int j = 0; j < RtSteps; j++) begin
            trial = ({33'd0, ro_reg[j]} << (RtSteps - j)) | (64'd1 << (2 * (RtSteps - 1 - j)));
            if ({2'b00, rm_reg[j]} >= trial) begin
                rm_next[j] = rm_reg[j] - trial[61:0];
                ro_next[j] = ro_reg[j] | (31'd1 << (RtSteps - 1 - j));
            end else begin
                rm_next[j] = rm_reg[j];
                ro_next[j] = ro_reg[j];
            end
        end
    end

    // Restoring division of the three scaled components by the length.
    always_comb begin
        logic [61:0] dv;
        for (int j = 0; j < DvSteps; j++) begin
            dv = {31'd0, ln_reg[j]} << (DvSteps - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (dr_reg[j][i] >= dv) begin
                    dr_next[j][i] = dr_reg[j][i] - dv;
                    qq_next[j][i] = qq_reg[j][i] | (31'd1 << (DvSteps - 1 - j));
                end else begin
                    dr_next[j][i] = dr_reg[j][i];
                    qq_next[j][i] = qq_reg[j][i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= ShSteps; k++) begin
                hs_reg[k].vld <= 1'b0;
            end
            hq_reg.vld <= 1'b0;
            for (int k = 0; k <= RtSteps; k++) begin
                hr_reg[k].vld <= 1'b0;
            end
            for (int k = 0; k <= DvSteps; k++) begin
                hd_reg[k].vld <= 1'b0;
            end
            ho_reg.vld <= 1'b0;
        end else if (en) begin
            hs_reg[0] <= '{vld: in_vld, side: in_side,
                           neg: {in_vec[2][63], in_vec[1][63], in_vec[0][63]},
                           zero: (max_next == 64'd0)};
            ms_reg[0] <= abs_next;
            xs_reg[0] <= max_next;
            for (int k = 0; k < ShSteps; k++) begin
                hs_reg[k+1] <= hs_reg[k];
                ms_reg[k+1] <= ms_next[k];
                xs_reg[k+1] <= xs_next[k];
            end

            hq_reg <= hs_reg[ShSteps];
            for (int i = 0; i < 3; i++) begin
                aq_reg[i] <= ms_reg[ShSteps][i][63:34];
                sq_reg[i] <= ms_reg[ShSteps][i][63:34] * ms_reg[ShSteps][i][63:34];
            end

            hr_reg[0] <= hq_reg;
            ar_reg[0] <= aq_reg;
            rm_reg[0] <= {2'b00, sq_reg[0]} + {2'b00, sq_reg[1]} + {2'b00, sq_reg[2]};
            ro_reg[0] <= '0;
            for (int j = 0; j < RtSteps; j++) begin
                hr_reg[j+1] <= hr_reg[j];
                ar_reg[j+1] <= ar_reg[j];
                rm_reg[j+1] <= rm_next[j];
                ro_reg[j+1] <= ro_next[j];
            end

            hd_reg[0] <= hr_reg[RtSteps];
            ln_reg[0] <= ro_reg[RtSteps];
            for (int i = 0; i < 3; i++) begin
                dr_reg[0][i] <= {2'b00, ar_reg[RtSteps][i], 30'd0}
                              + {32'd0, ro_reg[RtSteps][30:1]};
            end
            qq_reg[0] <= '0;
            for (int j = 0; j < DvSteps; j++) begin
                hd_reg[j+1] <= hd_reg[j];
                ln_reg[j+1] <= ln_reg[j];
                dr_reg[j+1] <= dr_next[j];
                qq_reg[j+1] <= qq_next[j];
            end

            ho_reg <= hd_reg[DvSteps];
            for (int i = 0; i < 3; i++) begin
                if (hd_reg[DvSteps].zero) begin
                    uo_reg[i] <= '0;
                end else if (hd_reg[DvSteps].neg[i]) begin
                    uo_reg[i] <= 32'd0 - {1'b0, qq_reg[DvSteps][i]};
                end else begin
                    uo_reg[i] <= {1'b0, qq_reg[DvSteps][i]};
                end
            end
        end
    end

    assign out_vld  = ho_reg.vld;
    assign out_unit = uo_reg;
    assign out_ok   = !ho_reg.zero;
    assign out_side = ho_reg.side;

endmodule

>>> hdl/look_at_view_matrix.sv
// Look-at view matrix in signed Q16.16. A transaction on the slave side carries eye, target
// and up vectors; the block answers with four master-side transactions, matrix columns 0 to 3
// in order, tlast on column 3 and tuser set when target equals eye or up is parallel to the
// view direction (all elements are then zero). Most of the pipeline lies in the two normalizers,
// each a 31-stage square root followed by a 31-stage divider. One column leaves per cycle while
// the master side is ready, and the next matrix loads as the last column of the previous one is
// taken, so the block takes one new input per matrix sent; the pipeline holds many inputs in
// flight and stalls as a whole when the output is not taken.
module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z; 32 bits each
    input  logic [InBits-1:0]   s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // column (2), elem0, elem1, elem2, elem3 (32 each), zero fill (6)
    output logic [OutBits-1:0]  m_tdata,
    output logic                m_tlast,
    // degenerate
    output logic                m_tuser
);

    logic             adv;
    logic             ser_load;

    q_t [2:0]         in_eye;
    q_t [2:0]         in_tgt;
    q_t [2:0]         in_up;
    logic [2:0][63:0] d_vec;
    side_t            side1_in;

    logic             n1_vld;
    q_t [2:0]         n1_unit;
    logic             n1_ok;
    side_t            n1_side;

    logic                     c1_vld_reg;
    side_t                    c1_side_reg;
    logic signed [5:0][63:0]  c1_p_reg;
    logic [2:0][63:0]         c_vec;

    logic             n2_vld;
    q_t [2:0]         n2_unit;
    logic             n2_ok;
    side_t            n2_side;

    logic                     u1_vld_reg;
    side_t                    u1_side_reg;
    q_t [2:0]                 u1_s_reg;
    logic                     u1_deg_reg;
    logic signed [5:0][63:0]  u1_p_reg;

    logic             u2_vld_reg;
    side_t            u2_side_reg;
    q_t [2:0]         u2_s_reg;
    q_t [2:0]         u2_u_reg;
    logic             u2_deg_reg;

    logic                     d1_vld_reg;
    q_t [2:0]                 d1_s_reg;
    q_t [2:0]                 d1_u_reg;
    q_t [2:0]                 d1_f_reg;
    logic                     d1_deg_reg;
    logic signed [8:0][63:0]  d1_p_reg;

    logic             fin_vld_reg;
    q_t [3:0][3:0]    fin_mat_reg;
    logic             fin_deg_reg;
    q_t [3:0][3:0]    fin_mat_next;

    q_t [3:0][3:0]    mat_reg;
    logic [1:0]       col_reg;
    logic             busy_reg;
    logic             deg_reg;

    always_comb begin
        logic signed [63:0] ew;
        logic signed [63:0] tw;
        for (int i = 0; i < 3; i++) begin
            in_eye[i] = s_tdata[32*i +: 32];
            in_tgt[i] = s_tdata[96 + 32*i +: 32];
            in_up[i]  = s_tdata[192 + 32*i +: 32];
            ew = in_eye[i];
            tw = in_tgt[i];
            d_vec[i] = tw - ew;
        end
        side1_in = '{eye: in_eye, up: in_up, f: '0, ok: 1'b0};
    end

    assign s_tready = adv;

    lav_nrm u_nrm_f (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (s_tvalid),
        .in_vec   (d_vec),
        .in_side  (side1_in),
        .out_vld  (n1_vld),
        .out_unit (n1_unit),
        .out_ok   (n1_ok),
        .out_side (n1_side)
    );

    always_comb begin
        c_vec[0] = c1_p_reg[0] - c1_p_reg[1];
        c_vec[1] = c1_p_reg[2] - c1_p_reg[3];
        c_vec[2] = c1_p_reg[4] - c1_p_reg[5];
    end

    lav_nrm u_nrm_s (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (c1_vld_reg),
        .in_vec   (c_vec),
        .in_side  (c1_side_reg),
        .out_vld  (n2_vld),
        .out_unit (n2_unit),
        .out_ok   (n2_ok),
        .out_side (n2_side)
    );

    always_comb begin
        logic signed [63:0] sum_s;
        logic signed [63:0] sum_u;
        logic signed [63:0] sum_f;
        sum_s = d1_p_reg[0] + d1_p_reg[1] + d1_p_reg[2];
        sum_u = d1_p_reg[3] + d1_p_reg[4] + d1_p_reg[5];
        sum_f = d1_p_reg[6] + d1_p_reg[7] + d1_p_reg[8];
        for (int k = 0; k < 3; k++) begin
            fin_mat_next[k][0] = 32'(rnd_shr(64'(d1_s_reg[k]), ElemFrac));
            fin_mat_next[k][1] = 32'(rnd_shr(64'(d1_u_reg[k]), ElemFrac));
            fin_mat_next[k][2] = 32'(rnd_shr(64'd0 - 64'(d1_f_reg[k]), ElemFrac));
            fin_mat_next[k][3] = '0;
        end
        fin_mat_next[3][0] = sat32(64'd0 - rnd_shr(sum_s, ProdFrac));
        fin_mat_next[3][1] = sat32(64'd0 - rnd_shr(sum_u, ProdFrac));
        fin_mat_next[3][2] = sat32(rnd_shr(sum_f, ProdFrac));
        fin_mat_next[3][3] = Q16One;
        if (d1_deg_reg) begin
            fin_mat_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_vld_reg  <= 1'b0;
            u1_vld_reg  <= 1'b0;
            u2_vld_reg  <= 1'b0;
            d1_vld_reg  <= 1'b0;
            fin_vld_reg <= 1'b0;
        end else if (adv) begin
            c1_vld_reg  <= n1_vld;
            c1_side_reg <= '{eye: n1_side.eye, up: n1_side.up, f: n1_unit, ok: n1_ok};
            c1_p_reg[0] <= mul32(n1_unit[1], n1_side.up[2]);
            c1_p_reg[1] <= mul32(n1_unit[2], n1_side.up[1]);
            c1_p_reg[2] <= mul32(n1_unit[2], n1_side.up[0]);
            c1_p_reg[3] <= mul32(n1_unit[0], n1_side.up[2]);
            c1_p_reg[4] <= mul32(n1_unit[0], n1_side.up[1]);
            c1_p_reg[5] <= mul32(n1_unit[1], n1_side.up[0]);

            u1_vld_reg  <= n2_vld;
            u1_side_reg <= n2_side;
            u1_s_reg    <= n2_unit;
            u1_deg_reg  <= !(n2_side.ok && n2_ok);
            u1_p_reg[0] <= mul32(n2_unit[1], n2_side.f[2]);
            u1_p_reg[1] <= mul32(n2_unit[2], n2_side.f[1]);
            u1_p_reg[2] <= mul32(n2_unit[2], n2_side.f[0]);
            u1_p_reg[3] <= mul32(n2_unit[0], n2_side.f[2]);
            u1_p_reg[4] <= mul32(n2_unit[0], n2_side.f[1]);
            u1_p_reg[5] <= mul32(n2_unit[1], n2_side.f[0]);

            u2_vld_reg  <= u1_vld_reg;
            u2_side_reg <= u1_side_reg;
            u2_s_reg    <= u1_s_reg;
            u2_deg_reg  <= u1_deg_reg;
            u2_u_reg[0] <= 32'(rnd_shr(u1_p_reg[0] - u1_p_reg[1], ProdFrac));
            u2_u_reg[1] <= 32'(rnd_shr(u1_p_reg[2] - u1_p_reg[3], ProdFrac));
            u2_u_reg[2] <= 32'(rnd_shr(u1_p_reg[4] - u1_p_reg[5], ProdFrac));

            d1_vld_reg <= u2_vld_reg;
            d1_s_reg   <= u2_s_reg;
            d1_u_reg   <= u2_u_reg;
            d1_f_reg   <= u2_side_reg.f;
            d1_deg_reg <= u2_deg_reg;
            for (int i = 0; i < 3; i++) begin
                d1_p_reg[i]     <= mul32(u2_s_reg[i], u2_side_reg.eye[i]);
                d1_p_reg[3 + i] <= mul32(u2_u_reg[i], u2_side_reg.eye[i]);
                d1_p_reg[6 + i] <= mul32(u2_side_reg.f[i], u2_side_reg.eye[i]);
            end

            fin_vld_reg <= d1_vld_reg;
            fin_mat_reg <= fin_mat_next;
            fin_deg_reg <= d1_deg_reg;
        end
    end

    assign ser_load = fin_vld_reg && (!busy_reg || (m_tready && col_reg == 2'd3));
    assign adv      = !fin_vld_reg || ser_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            col_reg  <= 2'd0;
        end else if (ser_load) begin
            busy_reg <= 1'b1;
            col_reg  <= 2'd0;
            mat_reg  <= fin_mat_reg;
            deg_reg  <= fin_deg_reg;
        end else if (busy_reg && m_tready) begin
            if (col_reg == 2'd3) begin
                busy_reg <= 1'b0;
            end
            col_reg <= col_reg + 2'd1;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = {6'd0, mat_reg[col_reg][3], mat_reg[col_reg][2],
                       mat_reg[col_reg][1], mat_reg[col_reg][0], col_reg};
    assign m_tlast  = (col_reg == 2'd3);
    assign m_tuser  = deg_reg;

    a_fin_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_vld_reg && !ser_load |=> fin_vld_reg && $stable(fin_mat_reg))
        else $error("finished matrix was dropped while the serializer was busy");

    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && m_tready && col_reg != 2'd3 |=> busy_reg && col_reg == $past(col_reg) + 2'd1)
        else $error("column counter did not advance on a taken transaction");

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[129:2] == 128'd0)
        else $error("degenerate column carries nonzero elements");

    a_load_start: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_load |=> busy_reg && col_reg == 2'd0)
        else $error("new matrix did not start at column zero");

endmodule

>>> verif/look_at_view_matrix_tb.sv
module look_at_view_matrix_tb;
    import lav_pkg::*;

    typedef struct {
        logic [1:0]  column;
        logic [31:0] elem [4];
        logic        last;
        logic        degenerate;
    } column_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z; 32 bits each
    logic [InBits-1:0]  s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    // column (2), elem0, elem1, elem2, elem3 (32 each), zero fill (6)
    logic [OutBits-1:0] m_tdata;
    logic               m_tlast;
    // degenerate
    logic               m_tuser;

    column_t     expected_columns[$];
    int          error_count;
    int          cycle_count;
    int          column_count;
    int          matrix_count;
    int          degenerate_count;
    int          hold_cycles;
    int          sink_wait;
    bit          sink_random;
    logic [287:0] seen_ones;
    logic [287:0] seen_zeros;

    look_at_view_matrix dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic logic [63:0] magnitude(input logic signed [63:0] x);
        return x < 0 ? -x : x;
    endfunction

    function automatic logic signed [63:0] shift_round(input logic signed [63:0] x, input int n);
        logic [63:0] m;
        m = magnitude(x);
        m = (m + (64'd1 << (n - 1))) >> n;
        return x < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bit normalize(input logic signed [63:0] v [3],
                                     output logic signed [63:0] o [3]);
        logic [63:0] a [3];
        logic [63:0] peak;
        logic [63:0] len;
        logic [63:0] q;
        int msb;
        peak = 0;
        msb = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = magnitude(v[i]);
            if (a[i] > peak) begin
                peak = a[i];
            end
            o[i] = 0;
        end
        if (peak == 0) begin
            return 1'b0;
        end
        while (msb < 64 && (peak >> msb) != 0) begin
            msb++;
        end
        for (int i = 0; i < 3; i++) begin
            a[i] = msb > 30 ? a[i] >> (msb - 30) : a[i] << (30 - msb);
        end
        len = floor_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        for (int i = 0; i < 3; i++) begin
            q = ((a[i] << 30) + (len >> 1)) / len;
            o[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
        return 1'b1;
    endfunction

    task automatic predict_view_matrix(input logic [287:0] data);
        logic signed [63:0] eye [3];
        logic signed [63:0] up [3];
        logic signed [63:0] d [3];
        logic signed [63:0] f [3];
        logic signed [63:0] c [3];
        logic signed [63:0] s [3];
        logic signed [63:0] u [3];
        logic signed [63:0] el [4][4];
        column_t col;
        bit ok_f;
        bit ok_s;
        bit degenerate;
        for (int i = 0; i < 3; i++) begin
            eye[i] = $signed(data[32*i +: 32]);
            up[i] = $signed(data[32*(6+i) +: 32]);
            d[i] = $signed(data[32*(3+i) +: 32]) - eye[i];
        end
        ok_f = normalize(d, f);
        c[0] = f[1] * up[2] - f[2] * up[1];
        c[1] = f[2] * up[0] - f[0] * up[2];
        c[2] = f[0] * up[1] - f[1] * up[0];
        ok_s = normalize(c, s);
        u[0] = shift_round(s[1] * f[2] - s[2] * f[1], 30);
        u[1] = shift_round(s[2] * f[0] - s[0] * f[2], 30);
        u[2] = shift_round(s[0] * f[1] - s[1] * f[0], 30);
        degenerate = !(ok_f && ok_s);
        for (int k = 0; k < 3; k++) begin
            el[k][0] = shift_round(s[k], 14);
            el[k][1] = shift_round(u[k], 14);
            el[k][2] = shift_round(-f[k], 14);
            el[k][3] = 0;
        end
        el[3][0] = clamp32(-shift_round(s[0]*eye[0] + s[1]*eye[1] + s[2]*eye[2], 30));
        el[3][1] = clamp32(-shift_round(u[0]*eye[0] + u[1]*eye[1] + u[2]*eye[2], 30));
        el[3][2] = clamp32(shift_round(f[0]*eye[0] + f[1]*eye[1] + f[2]*eye[2], 30));
        el[3][3] = 64'sd65536;
        for (int k = 0; k < 4; k++) begin
            col.column = k[1:0];
            for (int i = 0; i < 4; i++) begin
                col.elem[i] = degenerate ? 32'd0 : el[k][i][31:0];
            end
            col.last = (k == 3);
            col.degenerate = degenerate;
            expected_columns.push_back(col);
        end
    endtask

    // The valid stays high after a transaction and drops only before an idle stretch.
    task automatic send_camera(input logic [287:0] data, input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) begin
            gap = 0;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        seen_ones = seen_ones | data;
        seen_zeros = seen_zeros | ~data;
        predict_view_matrix(data);
    endtask

    function automatic logic [287:0] pack_camera(input logic [31:0] ex, ey, ez,
                                                 tx, ty, tz, ux, uy, uz);
        return {uz, uy, ux, tz, ty, tx, ez, ey, ex};
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            default: return ($signed($urandom_range(0, 200000)) - 100000) <<< 10;
        endcase
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_columns.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        logic [31:0] mx;
        logic [31:0] mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        send_camera(pack_camera(0, 0, 32'h0005_0000, 0, 0, 0, 0, 32'h0001_0000, 0));
        send_camera(pack_camera(1, 2, 3, 1, 2, 3, 0, 32'h0001_0000, 0));
        send_camera(pack_camera(0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0));
        send_camera(pack_camera(0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0003_0000));
        send_camera(pack_camera(0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 32'hFFFE_0000));
        send_camera(pack_camera(mx, mx, mx, mn, mn, mn, 0, 32'h0001_0000, 0));
        send_camera(pack_camera(mn, mn, mn, mx, mx, mx, mx, mn, mx));
        send_camera(pack_camera(mx, mn, mx, mn, mx, mn, mn, mn, mx));
        send_camera(pack_camera(mx, 0, 0, mn, 0, 0, 0, 0, 1));
        send_camera(pack_camera(mn, mx, 0, mx, mn, 1, 1, 0, 0));
        send_camera(pack_camera(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_camera(pack_camera(32'hFFFF_FFFF, 0, 0, 0, 32'hFFFF_FFFF, 0, mx, mx, mx));
        send_camera(pack_camera(mx, mx, mx, 0, 0, 0, 1, 1, 1));
        send_camera(pack_camera(mn, mn, mn, 0, 0, 0, mn, 1, mn));
        send_camera(pack_camera(32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
                                0, 0, 0, 32'hFFFF_0000, 32'h0002_0000, 0));
        send_camera(pack_camera(mx, mx, mx, mx, mx, mx, mx, mx, mx));
        send_camera(pack_camera(mn, mn, mn, mn, mn, mn, mn, mn, mn));
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic [31:0] v [9];
        int kind;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 9; i++) begin
                v[i] = random_coord();
            end
            kind = $urandom_range(0, 15);
            if (kind == 0) begin
                v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
            end else if (kind == 1) begin
                v[6] = $signed(v[3]) >>> 4;
                v[7] = $signed(v[4]) >>> 4;
                v[8] = $signed(v[5]) >>> 4;
                v[0] = 0; v[1] = 0; v[2] = 0;
            end else if (kind == 2) begin
                v[6] = 0; v[7] = 0; v[8] = 0;
            end
            send_camera(pack_camera(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]));
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 600;
        for (int n = 0; n < 200; n++) begin
            send_camera(pack_camera(random_coord(), random_coord(), random_coord(),
                                    random_coord(), random_coord(), random_coord(),
                                    random_coord(), random_coord(), random_coord()), 1'b1);
        end
        wait_drained();
    endtask

    always @(posedge aclk) begin
        int draw;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else if (!sink_random) begin
            m_tready <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            draw = $urandom_range(0, 7);
            sink_wait <= draw;
            m_tready <= (draw == 0);
        end else if (sink_wait > 0) begin
            sink_wait <= sink_wait - 1;
            m_tready <= (sink_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        column_t exp_col;
        if (aresetn && m_tvalid && m_tready) begin
            column_count++;
            if (expected_columns.size() == 0) begin
                $error("unexpected column transaction, column %0d", m_tdata[1:0]);
                error_count++;
            end else begin
                exp_col = expected_columns.pop_front();
                if (m_tdata[1:0] !== exp_col.column) begin
                    $error("column: expected %0d, actual %0d", exp_col.column, m_tdata[1:0]);
                    error_count++;
                end
                for (int i = 0; i < 4; i++) begin
                    if (m_tdata[2 + 32*i +: 32] !== exp_col.elem[i]) begin
                        $error("elem%0d: expected %h, actual %h", i, exp_col.elem[i],
                               m_tdata[2 + 32*i +: 32]);
                        error_count++;
                    end
                end
                if (m_tlast !== exp_col.last) begin
                    $error("last: expected %b, actual %b", exp_col.last, m_tlast);
                    error_count++;
                end
                if (m_tuser !== exp_col.degenerate) begin
                    $error("degenerate: expected %b, actual %b", exp_col.degenerate, m_tuser);
                    error_count++;
                end
                if (exp_col.last) begin
                    matrix_count++;
                    degenerate_count += exp_col.degenerate;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("look_at_view_matrix: mismatch");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        error_count = 0;
        cycle_count = 0;
        column_count = 0;
        matrix_count = 0;
        degenerate_count = 0;
        hold_cycles = 0;
        sink_wait = 0;
        sink_random = 1'b0;
        seen_ones = '0;
        seen_zeros = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        sink_random = 1'b1;
        test_random(120);
        wait_drained();
        sink_random = 1'b0;
        test_random(40);
        test_backpressure();
        sink_random = 1'b1;
        test_random(50);
        wait_drained();
        repeat (200) @(posedge aclk);
        $display("Checked %0d matrices (%0d degenerate), %0d column transactions in total.",
                 matrix_count, degenerate_count, column_count);
        $display("Input bits seen at both values: %0d of 288.",
                 $countones(seen_ones & seen_zeros));
        if (error_count == 0 && expected_columns.size() == 0) begin
            $display("look_at_view_matrix: match");
        end else begin
            $display("look_at_view_matrix: mismatch");
        end
        $finish;
    end
endmodule
